>>> sv/pfbb_pkg.sv
// Shared types and constants for the page framebuffer blitter.
package pfbb_pkg;

	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;
	localparam int CELL              = 8;
	// coordinate width, holds every clipped or unclipped edge used in drawing
	localparam int CW                = 12;
	localparam int GLYPH_W           = 64;

	localparam logic [7:0] CHAR_NEWLINE    = 8'd10;
	localparam logic [7:0] CHAR_DRAW_LIMIT = 8'd128;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_RECT   = 3'd1,
		OP_ORIGIN = 3'd2,
		OP_CHAR   = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	typedef logic signed [CW-1:0] coord_t;

	// one drawing job for the byte walker
	typedef struct packed {
		logic               clr;
		logic               glyph_mode;
		logic               fill;
		coord_t             org_x;
		coord_t             x_last;
		coord_t             org_y;
		coord_t             y_last;
		logic [GLYPH_W-1:0] glyph;
	} job_t;

	// character placement request from the text unit
	typedef struct packed {
		logic   draw;
		coord_t x;
		coord_t y;
	} cdraw_t;

endpackage

>>> sv/pfbb_store.sv
// Framebuffer memory: one write port, one read port with registered data.
module pfbb_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> sv/pfbb_walker.sv
// Byte walker: clips a job to the screen and read-modify-writes each byte it covers.
module pfbb_walker #(
	parameter int SCREEN_WIDTH  = pfbb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = pfbb_pkg::SCREEN_HEIGHT_DEF,
	parameter int AW            = $clog2(SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8))
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  pfbb_pkg::job_t       job,
	output logic                 busy,
	output logic [AW-1:0]        rd_addr,
	input  logic [7:0]           rd_data,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output logic [7:0]           wr_data
);

	localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
	localparam int XW          = $clog2(SCREEN_WIDTH);
	localparam int PGW         = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int RW          = PGW + 3;
	localparam int CW          = pfbb_pkg::CW;

	localparam pfbb_pkg::coord_t W_LAST = CW'(SCREEN_WIDTH - 1);
	localparam pfbb_pkg::coord_t H_LAST = CW'(SCREEN_HEIGHT - 1);
	localparam pfbb_pkg::coord_t ZERO_C = '0;

	typedef enum logic [2:0] {
		W_IDLE  = 3'b001,
		W_SETUP = 3'b010,
		W_RUN   = 3'b100
	} wstate_t;

	wstate_t         state_q;
	pfbb_pkg::job_t  job_q;

	logic [XW-1:0]   x_q, x_end_q;
	logic [PGW-1:0]  pg_q, pg_first_q, pg_end_q;
	logic [RW-1:0]   ys_q, ye_q;

	logic            v_s1, clr_s1;
	logic [AW-1:0]   addr_s1;
	logic [7:0]      mask_s1;

	pfbb_pkg::coord_t xs, xe, ys, ye;
	logic             empty;

	logic [AW-1:0]    addr;
	logic [7:0]       mask;
	logic [2:0]       col;
	logic [7:0]       gbyte;
	pfbb_pkg::coord_t x_c, row_c;
	logic             xedge;
	logic [RW-1:0]    row_v;
	logic [2:0]       gr;
	logic             bit_v;

	// clipping of the job rectangle
	always_comb begin
		xs    = (job_q.org_x < ZERO_C) ? ZERO_C : job_q.org_x;
		xe    = (job_q.x_last > W_LAST) ? W_LAST : job_q.x_last;
		ys    = (job_q.org_y < ZERO_C) ? ZERO_C : job_q.org_y;
		ye    = (job_q.y_last > H_LAST) ? H_LAST : job_q.y_last;
		empty = (xs > xe) || (ys > ye);
	end

	assign addr    = AW'(32'(pg_q) * 32'(SCREEN_WIDTH) + 32'(x_q));
	assign rd_addr = addr;

	// per-byte OR mask
	always_comb begin
		col   = x_q[2:0] - job_q.org_x[2:0];
		gbyte = job_q.glyph[{col, 3'b000} +: 8];
		x_c   = $signed(CW'(x_q));
		xedge = (x_c == job_q.org_x) || (x_c == job_q.x_last);
		row_v = '0;
		row_c = '0;
		gr    = '0;
		bit_v = 1'b0;
		mask  = '0;
		for (int r = 0; r < 8; r++) begin
			row_v = {pg_q, 3'(r)};
			row_c = $signed(CW'(row_v));
			gr    = row_c[2:0] - job_q.org_y[2:0];
			if (job_q.glyph_mode) begin
				bit_v = gbyte[gr];
			end else begin
				bit_v = job_q.fill || xedge || (row_c == job_q.org_y) ||
					(row_c == job_q.y_last);
			end
			mask[r] = bit_v && (row_v >= ys_q) && (row_v <= ye_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= (state_q == W_RUN);
			unique case (state_q)
				W_IDLE: begin
					if (start) begin
						state_q <= W_SETUP;
					end
				end
				W_SETUP: begin
					state_q <= empty ? W_IDLE : W_RUN;
				end
				W_RUN: begin
					if (pg_q == pg_end_q && x_q == x_end_q) begin
						state_q <= W_IDLE;
					end
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == W_IDLE && start) begin
			job_q <= job;
		end
		if (state_q == W_SETUP) begin
			x_q        <= XW'(xs);
			x_end_q    <= XW'(xe);
			pg_q       <= PGW'(ys >>> 3);
			pg_first_q <= PGW'(ys >>> 3);
			pg_end_q   <= PGW'(ye >>> 3);
			ys_q       <= RW'(ys);
			ye_q       <= RW'(ye);
		end else if (state_q == W_RUN) begin
			if (pg_q == pg_end_q) begin
				pg_q <= pg_first_q;
				x_q  <= x_q + XW'(1);
			end else begin
				pg_q <= pg_q + PGW'(1);
			end
		end
		addr_s1 <= addr;
		mask_s1 <= mask;
		clr_s1  <= job_q.clr;
	end

	// write back in the cycle after the read was issued; addresses never repeat in a job
	assign wr_en   = v_s1;
	assign wr_addr = addr_s1;
	assign wr_data = clr_s1 ? 8'h00 : (rd_data | mask_s1);
	assign busy    = (state_q != W_IDLE) || v_s1;

endmodule

>>> sv/pfbb_text.sv
// Text cursor unit: origin, newline, auto-wrap and halt at the bottom edge.
module pfbb_text #(
	parameter int SCREEN_WIDTH  = pfbb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = pfbb_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  pfbb_pkg::op_t       op,
	input  logic signed [8:0]   pos_x,
	input  logic signed [8:0]   pos_y,
	input  logic [7:0]          char_code,
	output logic                halted_next,
	output pfbb_pkg::cdraw_t    cdraw
);

	localparam int CW = pfbb_pkg::CW;
	localparam logic signed [9:0]   CELL10 = 10'(pfbb_pkg::CELL);
	localparam pfbb_pkg::coord_t    CELL_C = CW'(pfbb_pkg::CELL);
	localparam pfbb_pkg::coord_t    W_C    = CW'(SCREEN_WIDTH);
	localparam pfbb_pkg::coord_t    H_C    = CW'(SCREEN_HEIGHT);

	logic signed [9:0] cx_q, cy_q, ox_q;
	logic              halted_q;

	logic signed [9:0] cy8, dcx, dcy, nx, ny, nox;
	logic              lf_halt, wrap, nh, draw;

	always_comb begin
		cy8     = cy_q + CELL10;
		lf_halt = (CW'(cy8) + CELL_C) > H_C;
		wrap    = (CW'(cx_q) + CELL_C) > W_C;
		dcx     = wrap ? ox_q : cx_q;
		dcy     = wrap ? cy8 : cy_q;
		nx      = cx_q;
		ny      = cy_q;
		nox     = ox_q;
		nh      = halted_q;
		draw    = 1'b0;
		unique case (op)
			pfbb_pkg::OP_ORIGIN: begin
				nox = 10'(pos_x);
				nx  = 10'(pos_x);
				ny  = 10'(pos_y);
				nh  = 1'b0;
			end
			pfbb_pkg::OP_CHAR: begin
				if (!halted_q) begin
					// newline, or a wrap that runs off the bottom: line feed only
					if (char_code == pfbb_pkg::CHAR_NEWLINE || (wrap && lf_halt)) begin
						nx = ox_q;
						ny = cy8;
						nh = lf_halt;
					end else begin
						nx   = dcx + CELL10;
						ny   = dcy;
						draw = char_code < pfbb_pkg::CHAR_DRAW_LIMIT;
					end
				end
			end
			default: ;
		endcase
		halted_next = nh;
		cdraw.draw  = draw;
		cdraw.x     = CW'(dcx);
		cdraw.y     = CW'(dcy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			ox_q     <= '0;
			halted_q <= 1'b0;
		end else if (upd) begin
			cx_q     <= nx;
			cy_q     <= ny;
			ox_q     <= nox;
			halted_q <= nh;
		end
	end

endmodule

>>> sv/page_framebuffer_rect_text_blitter_core.sv
// Monochrome page framebuffer blitter, top level.
// The block holds a SCREEN_WIDTH x SCREEN_HEIGHT 1-bit picture in one synchronous
// memory of SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes (pixel x,y is bit y%8 of byte
// x + (y/8)*SCREEN_WIDTH). Every accepted word returns exactly one result word.
// Drawing is done by a byte walker that reads, ORs and writes back one byte per
// cycle through the memory's single read and write port: a clear walks every
// byte (1024 at the default size), a rectangle walks its clipped columns times its
// clipped pages, a character at most 16 bytes. A read passes through a read state
// before its result is registered; origin and unused op codes register theirs
// directly. After reset the same walker zeroes the whole memory before the first
// word is taken. The input is held off while any walk or write-back is in flight.
module page_framebuffer_rect_text_blitter_core #(
	parameter int SCREEN_WIDTH  = pfbb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = pfbb_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          op,
	input  logic signed [8:0]   pos_x,
	input  logic signed [8:0]   pos_y,
	input  logic [7:0]          rect_width,
	input  logic [7:0]          rect_height,
	input  logic                fill_mode,
	input  logic [7:0]          char_code,
	input  logic [63:0]         glyph_columns,
	input  logic [9:0]          read_address,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          read_data,
	output logic                text_halted
);

	localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
	localparam int FRAME_BYTES = SCREEN_WIDTH * PAGES;
	localparam int AW          = $clog2(FRAME_BYTES);
	localparam int CW          = pfbb_pkg::CW;

	typedef enum logic [2:0] {
		ST_INIT = 3'b001,
		ST_IDLE = 3'b010,
		ST_READ = 3'b100
	} state_t;

	state_t            st_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;
	logic              out_halted_q;
	logic              rd_in_range_q;

	pfbb_pkg::op_t     op_c;
	logic              accept;
	logic              halted_next;
	pfbb_pkg::cdraw_t  cdraw;
	pfbb_pkg::job_t    job;
	logic              walk_start, walk_busy;

	logic [AW-1:0]     walk_rd_addr, rd_addr, wr_addr;
	logic [7:0]        rd_data, wr_data;
	logic              wr_en;

	assign op_c     = pfbb_pkg::op_t'(op);
	assign in_ready = (st_q == ST_IDLE) && !walk_busy && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	pfbb_text #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_text (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (accept),
		.op          (op_c),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.char_code   (char_code),
		.halted_next (halted_next),
		.cdraw       (cdraw)
	);

	// job selection
	always_comb begin
		job            = '0;
		job.glyph      = glyph_columns;
		job.fill       = fill_mode;
		walk_start     = 1'b0;
		if (st_q == ST_INIT) begin
			job.clr    = 1'b1;
			job.x_last = CW'(SCREEN_WIDTH - 1);
			job.y_last = CW'(SCREEN_HEIGHT - 1);
			walk_start = 1'b1;
		end else begin
			unique case (op_c)
				pfbb_pkg::OP_CLEAR: begin
					job.clr    = 1'b1;
					job.x_last = CW'(SCREEN_WIDTH - 1);
					job.y_last = CW'(SCREEN_HEIGHT - 1);
					walk_start = accept;
				end
				pfbb_pkg::OP_RECT: begin
					job.org_x  = CW'(pos_x);
					job.org_y  = CW'(pos_y);
					job.x_last = CW'(pos_x) + $signed(CW'(rect_width)) - CW'(1);
					job.y_last = CW'(pos_y) + $signed(CW'(rect_height)) - CW'(1);
					walk_start = accept;
				end
				pfbb_pkg::OP_CHAR: begin
					job.glyph_mode = 1'b1;
					job.org_x      = cdraw.x;
					job.org_y      = cdraw.y;
					job.x_last     = cdraw.x + CW'(pfbb_pkg::CELL - 1);
					job.y_last     = cdraw.y + CW'(pfbb_pkg::CELL - 1);
					walk_start     = accept && cdraw.draw;
				end
				default: ;
			endcase
		end
	end

	pfbb_walker #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.AW            (AW)
	) u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (walk_start),
		.job     (job),
		.busy    (walk_busy),
		.rd_addr (walk_rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign rd_addr = (accept && op_c == pfbb_pkg::OP_READ) ? AW'(read_address) : walk_rd_addr;

	pfbb_store #(
		.DEPTH (FRAME_BYTES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_INIT: st_q <= ST_IDLE;
				ST_IDLE: begin
					if (accept) begin
						if (op_c == pfbb_pkg::OP_READ) begin
							st_q <= ST_READ;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_READ: begin
					st_q        <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q    <= 8'h00;
			out_halted_q  <= halted_next;
			rd_in_range_q <= 32'(read_address) < FRAME_BYTES;
		end
		if (st_q == ST_READ) begin
			out_data_q <= rd_in_range_q ? rd_data : 8'h00;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = out_data_q;
	assign text_halted = out_halted_q;

endmodule

>>> sim/tb_page_framebuffer_rect_text_blitter_core.sv
// Testbench for the page framebuffer blitter core: predicted framebuffer, random traffic.
`timescale 1ns / 100ps

module tb_page_framebuffer_rect_text_blitter_core;

	localparam int SW          = pfbb_pkg::SCREEN_WIDTH_DEF;
	localparam int SH          = pfbb_pkg::SCREEN_HEIGHT_DEF;
	localparam int FRAME_BYTES = SW * ((SH + 7) / 8);
	localparam int RAND_WORDS  = 700;
	localparam int HOLD_AT     = 200;
	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYCLES = 64;

	// op codes the block leaves alone
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

	typedef struct {
		logic [2:0]        op;
		logic signed [8:0] pos_x;
		logic signed [8:0] pos_y;
		logic [7:0]        rect_width;
		logic [7:0]        rect_height;
		logic              fill_mode;
		logic [7:0]        char_code;
		logic [63:0]       glyph_columns;
		logic [9:0]        read_address;
	} blit_cmd_t;

	typedef struct {
		logic [7:0] data;
		logic       halted;
	} screen_reply_t;

	class blit_scoreboard;
		logic [7:0]        fb [FRAME_BYTES];
		logic signed [9:0] cur_col;
		logic signed [9:0] cur_row;
		logic signed [9:0] left_margin;
		logic              stopped;
		screen_reply_t     replies_due [$];
		int                errors;
		int                checked;
		int                halts;
		int                lit_reads;
		int                op_seen [8];

		function new();
			foreach (fb[i]) fb[i] = '0;
			cur_col     = '0;
			cur_row     = '0;
			left_margin = '0;
			stopped     = 1'b0;
		endfunction

		function void set_px(int px, int py);
			if (px < 0 || px >= SW || py < 0 || py >= SH)
				return;
			fb[px + (py / 8) * SW][py % 8] = 1'b1;
		endfunction

		function void line_feed();
			cur_col = left_margin;
			cur_row = cur_row + 10'(pfbb_pkg::CELL);
			if (int'(cur_row) + pfbb_pkg::CELL > SH)
				stopped = 1'b1;
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		// advance the picture by one accepted word and queue its reply
		function void take_command(blit_cmd_t c);
			screen_reply_t r;
			int x0, y0, w, h, i, j, i_lo, i_hi, j_lo, j_hi, col, row;
			logic was_stopped;
			r.data      = '0;
			was_stopped = stopped;
			op_seen[c.op]++;
			case (c.op)
				pfbb_pkg::OP_CLEAR: begin
					foreach (fb[k]) fb[k] = '0;
				end
				pfbb_pkg::OP_RECT: begin
					x0   = int'(c.pos_x);
					y0   = int'(c.pos_y);
					w    = int'(c.rect_width);
					h    = int'(c.rect_height);
					// only walk the visible part; outline test uses unclipped offsets
					i_lo = (x0 < 0) ? -x0 : 0;
					j_lo = (y0 < 0) ? -y0 : 0;
					i_hi = (SW - x0 < w) ? SW - x0 : w;
					j_hi = (SH - y0 < h) ? SH - y0 : h;
					for (j = j_lo; j < j_hi; j++)
						for (i = i_lo; i < i_hi; i++)
							if (c.fill_mode || j == 0 || j == h - 1 || i == 0 || i == w - 1)
								set_px(x0 + i, y0 + j);
				end
				pfbb_pkg::OP_ORIGIN: begin
					left_margin = {c.pos_x[8], c.pos_x};
					cur_col     = left_margin;
					cur_row     = {c.pos_y[8], c.pos_y};
					stopped     = 1'b0;
				end
				pfbb_pkg::OP_CHAR: begin
					if (!stopped) begin
						if (c.char_code == pfbb_pkg::CHAR_NEWLINE) begin
							line_feed();
						end else begin
							if (int'(cur_col) + pfbb_pkg::CELL > SW)
								line_feed();
							if (!stopped) begin
								if (c.char_code < pfbb_pkg::CHAR_DRAW_LIMIT)
									for (col = 0; col < 8; col++)
										for (row = 0; row < 8; row++)
											if (c.glyph_columns[col * 8 + row])
												set_px(int'(cur_col) + col, int'(cur_row) + row);
								cur_col = cur_col + 10'(pfbb_pkg::CELL);
							end
						end
					end
				end
				pfbb_pkg::OP_READ: begin
					if (int'(c.read_address) < FRAME_BYTES)
						r.data = fb[c.read_address];
					if (r.data != 0)
						lit_reads++;
				end
				default: ;
			endcase
			r.halted = stopped;
			if (stopped && !was_stopped)
				halts++;
			replies_due.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_reply(logic [7:0] data, logic halted);
			screen_reply_t want;
			if (replies_due.size() == 0) begin
				report($sformatf("unexpected word data=%h halted=%b", data, halted));
				return;
			end
			want = replies_due.pop_front();
			checked++;
			if (data !== want.data)
				report($sformatf("word %0d read_data %h, want %h", checked, data, want.data));
			if (halted !== want.halted)
				report($sformatf("word %0d text_halted %b, want %b", checked, halted,
					want.halted));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [2:0]        op;
	logic signed [8:0] pos_x;
	logic signed [8:0] pos_y;
	logic [7:0]        rect_width;
	logic [7:0]        rect_height;
	logic              fill_mode;
	logic [7:0]        char_code;
	logic [63:0]       glyph_columns;
	logic [9:0]        read_address;
	logic              out_valid;
	logic              out_ready;
	logic [7:0]        read_data;
	logic              text_halted;

	blit_scoreboard sb = new();
	bit             calm;
	int             words_sent;

	page_framebuffer_rect_text_blitter_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.rect_width   (rect_width),
		.rect_height  (rect_height),
		.fill_mode    (fill_mode),
		.char_code    (char_code),
		.glyph_columns(glyph_columns),
		.read_address (read_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_data    (read_data),
		.text_halted  (text_halted)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("FAIL");
		$finish;
	end

	// every field random, so unused fields toggle too
	function automatic blit_cmd_t noise_cmd();
		blit_cmd_t c;
		c.op            = 3'($urandom);
		c.pos_x         = 9'($urandom);
		c.pos_y         = 9'($urandom);
		c.rect_width    = 8'($urandom);
		c.rect_height   = 8'($urandom);
		c.fill_mode     = 1'($urandom);
		c.char_code     = 8'($urandom);
		c.glyph_columns = {$urandom, $urandom};
		c.read_address  = 10'($urandom);
		return c;
	endfunction

	// valid stays up across back-to-back words; lowered only when a gap follows
	task automatic send_word(blit_cmd_t c);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op            <= c.op;
		pos_x         <= c.pos_x;
		pos_y         <= c.pos_y;
		rect_width    <= c.rect_width;
		rect_height   <= c.rect_height;
		fill_mode     <= c.fill_mode;
		char_code     <= c.char_code;
		glyph_columns <= c.glyph_columns;
		read_address  <= c.read_address;
		in_valid      <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.take_command(c);
		words_sent++;
	endtask

	task automatic send_op(logic [2:0] code);
		blit_cmd_t c;
		c    = noise_cmd();
		c.op = code;
		send_word(c);
	endtask

	task automatic send_rect(int x, int y, int w, int h, bit fill);
		blit_cmd_t c;
		c             = noise_cmd();
		c.op          = pfbb_pkg::OP_RECT;
		c.pos_x       = 9'(x);
		c.pos_y       = 9'(y);
		c.rect_width  = 8'(w);
		c.rect_height = 8'(h);
		c.fill_mode   = fill;
		send_word(c);
	endtask

	task automatic send_origin(int x, int y);
		blit_cmd_t c;
		c       = noise_cmd();
		c.op    = pfbb_pkg::OP_ORIGIN;
		c.pos_x = 9'(x);
		c.pos_y = 9'(y);
		send_word(c);
	endtask

	task automatic send_char(logic [7:0] code, logic [63:0] glyph);
		blit_cmd_t c;
		c               = noise_cmd();
		c.op            = pfbb_pkg::OP_CHAR;
		c.char_code     = code;
		c.glyph_columns = glyph;
		send_word(c);
	endtask

	task automatic send_read(int addr);
		blit_cmd_t c;
		c              = noise_cmd();
		c.op           = pfbb_pkg::OP_READ;
		c.read_address = 10'(addr);
		send_word(c);
	endtask

	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// result side: random stalls, one long hold to back the block up
	initial begin
		int gap;
		int taken;
		taken = 0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 8);
			if (taken == HOLD_AT)
				gap = LONG_HOLD;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_reply(read_data, text_halted);
			taken++;
		end
	end

	initial begin
		int pick, rx, ry, rw, rh, n, k, r;
		int rand_start;
		bit mid_drained;
		blit_cmd_t c;
		mid_drained   = 1'b0;
		calm          = 1'b0;
		words_sent    = 0;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		op            <= pfbb_pkg::OP_CLEAR;
		pos_x         <= '0;
		pos_y         <= '0;
		rect_width    <= '0;
		rect_height   <= '0;
		fill_mode     <= 1'b0;
		char_code     <= '0;
		glyph_columns <= '0;
		read_address  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corners of the store, rectangle edges and text edge cases
		send_read(0);
		send_read(FRAME_BYTES - 1);
		send_rect(0, 0, SW, SH, 1'b0);
		send_read(0);
		send_read(1);
		send_read(7 * SW + 5);
		send_rect(10, 10, 0, 20, 1'b1);
		send_rect(10, 10, 20, 0, 1'b1);
		send_rect(-256, -256, 255, 255, 1'b1);
		send_rect(255, 255, 255, 255, 1'b1);
		send_rect(-4, -4, 20, 20, 1'b1);
		send_read(3);
		send_op(pfbb_pkg::OP_CLEAR);
		send_read(0);
		send_origin(0, 56);
		send_char(8'h41, '1);
		send_char(8'hC8, '1);              // high code: cursor moves, nothing drawn
		send_read(7 * SW);
		send_char(pfbb_pkg::CHAR_NEWLINE, '1);  // drops off the bottom -> halt
		send_char(8'h41, '1);              // ignored while halted
		send_origin(120, 48);
		send_char(8'h7F, {$urandom, $urandom});
		send_char(8'h00, '1);              // wraps to next text row
		send_origin(0, SH);                // first row below screen, no wrap yet
		send_char(8'h41, '1);
		send_origin(124, 56);
		send_char(8'h41, '1);              // wrap runs off the bottom, char dropped
		send_op(OP_SPARE_FIRST);
		send_op(OP_SPARE_LAST);
		send_read(7 * SW + 124);
		in_valid <= 1'b0;
		drain();

		rand_start = words_sent;
		while (words_sent < rand_start + RAND_WORDS) begin
			calm = (((words_sent - rand_start) / 50) % 6 == 3);
			if (!mid_drained && words_sent >= rand_start + RAND_WORDS / 2) begin
				in_valid <= 1'b0;
				drain();
				mid_drained = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				send_op(pfbb_pkg::OP_CLEAR);
			end else if (pick < 32) begin
				rx = ($urandom_range(0, 7) == 0) ? int'($signed(9'($urandom)))
					: int'($urandom_range(0, 150)) - 16;
				ry = ($urandom_range(0, 7) == 0) ? int'($signed(9'($urandom)))
					: int'($urandom_range(0, 80)) - 12;
				rw = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 255))
					: int'($urandom_range(0, 24));
				rh = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 255))
					: int'($urandom_range(0, 24));
				send_rect(rx, ry, rw, rh, 1'($urandom));
				n = $urandom_range(1, 3);
				for (k = 0; k < n; k++)
					send_read((((ry + int'($urandom_range(0, rh))) >>> 3) & 7) * SW
						+ ((rx + int'($urandom_range(0, rw))) & (SW - 1)));
			end else if (pick < 62) begin
				rx = ($urandom_range(0, 9) == 0) ? int'($signed(9'($urandom)))
					: int'($urandom_range(0, 136)) - 8;
				ry = ($urandom_range(0, 9) == 0) ? int'($signed(9'($urandom)))
					: int'($urandom_range(0, 72)) - 8;
				send_origin(rx, ry);
				n = $urandom_range(3, 20);
				for (k = 0; k < n; k++) begin
					r = $urandom_range(0, 99);
					if (r < 20)
						send_char(pfbb_pkg::CHAR_NEWLINE, {$urandom, $urandom});
					else if (r < 30)
						send_char(8'($urandom_range(128, 255)), {$urandom, $urandom});
					else
						send_char(8'($urandom_range(0, 127)), {$urandom, $urandom});
				end
				for (k = 0; k < 2; k++)
					send_read((((ry + int'($urandom_range(0, 23))) >>> 3) & 7) * SW
						+ ((rx + int'($urandom_range(0, 47))) & (SW - 1)));
			end else if (pick < 70) begin
				if ($urandom_range(0, 1) == 0) begin
					send_op(3'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST))));
				end else begin
					c = noise_cmd();
					send_word(c);
				end
			end else begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++)
					send_read($urandom_range(0, FRAME_BYTES - 1));
			end
		end
		in_valid <= 1'b0;
		calm = 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d words: clear %0d, rect %0d, origin %0d, char %0d, read %0d",
			words_sent, sb.op_seen[pfbb_pkg::OP_CLEAR], sb.op_seen[pfbb_pkg::OP_RECT],
			sb.op_seen[pfbb_pkg::OP_ORIGIN], sb.op_seen[pfbb_pkg::OP_CHAR],
			sb.op_seen[pfbb_pkg::OP_READ]);
		$display("replies checked %0d, text halts %0d, nonzero reads %0d, errors %0d",
			sb.checked, sb.halts, sb.lit_reads, sb.errors);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
